@@ sv/cemi_ldata_frame_parser_unit_defines.svh @@
// Assertion macros shared by the cEMI L_Data frame parser RTL.
`ifndef CEMI_LDATA_FRAME_PARSER_UNIT_DEFINES_SVH
`define CEMI_LDATA_FRAME_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CEMI_LDFP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cemi_ldfp: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CEMI_LDFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cemi_ldfp: next-cycle check failed");

`endif

@@ sv/cemi_ldfp_pkg.sv @@
// Types, constants and helpers for the cEMI L_Data frame parser.
`default_nettype none

package cemi_ldfp_pkg;

   // Supported message codes
   localparam logic [7:0] MC_L_DATA_REQ = 8'h11;
   localparam logic [7:0] MC_L_DATA_IND = 8'h29;
   localparam logic [7:0] MC_L_DATA_CON = 8'h2E;

   // Frame status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_SIZE  = 2'd1;
   localparam logic [1:0] STATUS_DECODE    = 2'd2;
   localparam logic [1:0] STATUS_OVER_CAP  = 2'd3;

   localparam logic [9:0]  POS_MAX         = 10'd1023;
   localparam logic [10:0] MIN_FRAME_SIZE  = 11'd11;
   localparam logic [8:0]  CAPACITY_RESET  = 9'd256;

   // One accepted input item
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } in_item_type;

   // One result item
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        frame_done;
      logic [1:0]  status;
      logic [7:0]  message_code;
      logic [3:0]  frame_flags;
      logic [1:0]  priority_res;
      logic        dest_is_group;
      logic [2:0]  hop_count;
      logic [15:0] source_address;
      logic [15:0] dest_address;
      logic [8:0]  payload_length;
   } rsp_item_type;

   function automatic logic code_supported(input logic [7:0] code);
      return (code == MC_L_DATA_REQ) || (code == MC_L_DATA_IND) ||
             (code == MC_L_DATA_CON);
   endfunction

endpackage

`default_nettype wire

@@ sv/cemi_ldata_frame_parser_unit.sv @@
// An accepted byte waits in the input register; its result is then loaded into the result register.
// Throughput: one byte per cycle while results are taken; the input register drains whenever the result
// register is empty or being taken, so a stalled result still lets one byte wait.
// Bytes that are neither payload nor last produce no result.
// Reset: frame state clears to the start of a frame, capacity_ff returns to 256.
`default_nettype none
`include "cemi_ldata_frame_parser_unit_defines.svh"

module cemi_ldata_frame_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_frame_byte,
   input  wire logic        req_last_byte,
   // result output
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_payload_valid,
   output logic             rsp_frame_done,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_message_code,
   output logic [3:0]       rsp_frame_flags,
   output logic [1:0]       rsp_priority_res,
   output logic             rsp_dest_is_group,
   output logic [2:0]       rsp_hop_count,
   output logic [15:0]      rsp_source_address,
   output logic [15:0]      rsp_dest_address,
   output logic [8:0]       rsp_payload_length,
   // configuration
   input  wire logic        csr_write_enable,
   input  wire logic [8:0]  csr_write_data
);

   logic                         item_valid, take, emit;
   cemi_ldfp_pkg::in_item_type   item;
   cemi_ldfp_pkg::rsp_item_type  result, out_ff;
   logic                         out_valid_ff, out_valid_in;
   logic [8:0]                   capacity_ff;

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= cemi_ldfp_pkg::CAPACITY_RESET;
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

   cemi_ldfp_in_stage u_in_stage (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_frame_byte (req_frame_byte),
      .req_last_byte  (req_last_byte),
      .take           (take),
      .item_valid     (item_valid),
      .item           (item)
   );

   // Held byte advances when the result register can take its result
   assign take = item_valid && (!out_valid_ff || rsp_ready);

   cemi_ldfp_core u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (take),
      .item     (item),
      .capacity (capacity_ff),
      .emit     (emit),
      .result   (result)
   );

   // Result register
   always_comb begin
      if (take && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_payload_valid  = out_ff.payload_valid;
   assign rsp_frame_done     = out_ff.frame_done;
   assign rsp_status         = out_ff.status;
   assign rsp_message_code   = out_ff.message_code;
   assign rsp_frame_flags    = out_ff.frame_flags;
   assign rsp_priority_res   = out_ff.priority_res;
   assign rsp_dest_is_group  = out_ff.dest_is_group;
   assign rsp_hop_count      = out_ff.hop_count;
   assign rsp_source_address = out_ff.source_address;
   assign rsp_dest_address   = out_ff.dest_address;
   assign rsp_payload_length = out_ff.payload_length;

   // Checks
   `CEMI_LDFP_ASSERT_NOW(a_no_empty_result, clock, reset, rsp_valid, rsp_payload_valid || rsp_frame_done)
   `CEMI_LDFP_ASSERT_NOW(a_idle_payload_zero, clock, reset, rsp_valid && !rsp_payload_valid, rsp_payload_byte == 8'd0)
   `CEMI_LDFP_ASSERT_NOW(a_header_only_at_end, clock, reset, rsp_valid && !rsp_frame_done, (rsp_status == cemi_ldfp_pkg::STATUS_OK) && (rsp_payload_length == 9'd0))
   `CEMI_LDFP_ASSERT_NOW(a_no_advance_on_stall, clock, reset, out_valid_ff && !rsp_ready, !take)
   `CEMI_LDFP_ASSERT_NEXT(a_stalled_result_kept, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(out_ff))

endmodule

`default_nettype wire

@@ sv/cemi_ldfp_in_stage.sv @@
// Input register stage of the cEMI L_Data frame parser.
`default_nettype none

module cemi_ldfp_in_stage (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [7:0]                req_frame_byte,
   input  wire logic                      req_last_byte,
   input  wire logic                      take,
   output logic                           item_valid,
   output cemi_ldfp_pkg::in_item_type     item
);

   logic                       valid_ff, valid_in;
   cemi_ldfp_pkg::in_item_type item_ff;

   // Slot is free when empty or being drained this cycle
   assign req_ready = !valid_ff || take;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.frame_byte <= req_frame_byte;
         item_ff.last_byte  <= req_last_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

@@ sv/cemi_ldfp_core.sv @@
// Frame state and per-byte field decode of the cEMI L_Data frame parser.
`default_nettype none

module cemi_ldfp_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire cemi_ldfp_pkg::in_item_type item,
   input  wire logic [8:0]                 capacity,
   output logic                            emit,
   output cemi_ldfp_pkg::rsp_item_type     result
);

   // Frame state
   logic [9:0]  pos_ff, pos_in;
   logic [7:0]  addinfo_ff, addinfo_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  ctrl1_ff, ctrl1_in;
   logic [7:0]  ctrl2_ff, ctrl2_in;
   logic [15:0] src_ff, src_in;
   logic [15:0] dst_ff, dst_in;

   logic [10:0] pos_w, ai_w, len_w, size, need;
   logic        pay;
   logic [1:0]  status;
   logic [7:0]  b;

   assign b     = item.frame_byte;
   assign pos_w = {1'b0, pos_ff};
   assign ai_w  = {3'b0, addinfo_ff};

   // Header field latch by position, payload window otherwise
   always_comb begin
      code_in    = code_ff;
      addinfo_in = addinfo_ff;
      ctrl1_in   = ctrl1_ff;
      ctrl2_in   = ctrl2_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      len_in     = len_ff;
      pay        = 1'b0;
      if (pos_ff == 10'd0) begin
         code_in = b;
      end else if (pos_ff == 10'd1) begin
         addinfo_in = b;
      end else if (pos_w == ai_w + 11'd2) begin
         ctrl1_in = b;
      end else if (pos_w == ai_w + 11'd3) begin
         ctrl2_in = b;
      end else if (pos_w == ai_w + 11'd4) begin
         src_in[15:8] = b;
      end else if (pos_w == ai_w + 11'd5) begin
         src_in[7:0] = b;
      end else if (pos_w == ai_w + 11'd6) begin
         dst_in[15:8] = b;
      end else if (pos_w == ai_w + 11'd7) begin
         dst_in[7:0] = b;
      end else if (pos_w == ai_w + 11'd8) begin
         len_in = b;
      end else begin
         pay = (pos_w >= ai_w + 11'd9) &&
               (pos_w < ai_w + {3'b0, len_ff} + 11'd10);
      end
   end

   // Frame size counts this byte; status uses the updated header
   assign size  = pos_w + 11'd1;
   assign len_w = {3'b0, len_in};
   assign need  = {3'b0, addinfo_in} + len_w + 11'd10;

   // First failing check wins; short frame checked first
   always_comb begin
      if (size < cemi_ldfp_pkg::MIN_FRAME_SIZE) begin
         status = cemi_ldfp_pkg::STATUS_BAD_SIZE;
      end else if (!cemi_ldfp_pkg::code_supported(code_in)) begin
         status = cemi_ldfp_pkg::STATUS_DECODE;
      end else if (size < {3'b0, addinfo_in} + 11'd4) begin
         status = cemi_ldfp_pkg::STATUS_BAD_SIZE;
      end else if (ctrl1_in[7] && (ctrl2_in[3:0] != 4'd0)) begin
         status = cemi_ldfp_pkg::STATUS_DECODE;
      end else if (size < {3'b0, addinfo_in} + 11'd10) begin
         status = cemi_ldfp_pkg::STATUS_BAD_SIZE;
      end else if (len_in == 8'd0) begin
         status = cemi_ldfp_pkg::STATUS_DECODE;
      end else if (size < need) begin
         status = cemi_ldfp_pkg::STATUS_BAD_SIZE;
      end else if ({1'b0, len_in} + 9'd1 > capacity) begin
         status = cemi_ldfp_pkg::STATUS_OVER_CAP;
      end else if (size != need) begin
         status = cemi_ldfp_pkg::STATUS_BAD_SIZE;
      end else begin
         status = cemi_ldfp_pkg::STATUS_OK;
      end
   end

   // Result assembly: header fields only on the last byte
   assign emit = pay || item.last_byte;

   always_comb begin
      result = '0;
      if (pay) begin
         result.payload_byte  = b;
         result.payload_valid = 1'b1;
      end
      if (item.last_byte) begin
         result.frame_done     = 1'b1;
         result.status         = status;
         result.message_code   = code_in;
         result.frame_flags    = {ctrl1_in[7], !ctrl1_in[5], ctrl1_in[1], ctrl1_in[0]};
         result.priority_res   = ctrl1_in[3:2];
         result.dest_is_group  = ctrl2_in[7];
         result.hop_count      = ctrl2_in[6:4];
         result.source_address = src_in;
         result.dest_address   = dst_in;
         result.payload_length = {1'b0, len_in} + 9'd1;
      end
   end

   // Position saturates; a last byte restarts the frame
   assign pos_in = (pos_ff == cemi_ldfp_pkg::POS_MAX) ? pos_ff : pos_ff + 10'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         addinfo_ff <= '0;
         len_ff     <= '0;
         code_ff    <= '0;
         ctrl1_ff   <= '0;
         ctrl2_ff   <= '0;
         src_ff     <= '0;
         dst_ff     <= '0;
      end else if (advance) begin
         if (item.last_byte) begin
            pos_ff     <= '0;
            addinfo_ff <= '0;
            len_ff     <= '0;
            code_ff    <= '0;
            ctrl1_ff   <= '0;
            ctrl2_ff   <= '0;
            src_ff     <= '0;
            dst_ff     <= '0;
         end else begin
            pos_ff     <= pos_in;
            addinfo_ff <= addinfo_in;
            len_ff     <= len_in;
            code_ff    <= code_in;
            ctrl1_ff   <= ctrl1_in;
            ctrl2_ff   <= ctrl2_in;
            src_ff     <= src_in;
            dst_ff     <= dst_in;
         end
      end
   end

endmodule

`default_nettype wire

@@ tb/cemi_ldata_frame_parser_unit_tb.sv @@
// Self-checking testbench for the cEMI L_Data frame parser: random frames, stalls, capacity sweep.
`default_nettype none

module cemi_ldata_frame_parser_unit_tb;

   localparam int CYCLE_LIMIT = 500000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_frame_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_payload_valid;
   logic        rsp_frame_done;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_message_code;
   logic [3:0]  rsp_frame_flags;
   logic [1:0]  rsp_priority_res;
   logic        rsp_dest_is_group;
   logic [2:0]  rsp_hop_count;
   logic [15:0] rsp_source_address;
   logic [15:0] rsp_dest_address;
   logic [8:0]  rsp_payload_length;
   logic        csr_write_enable;
   logic [8:0]  csr_write_data;

   cemi_ldata_frame_parser_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_frame_byte     (req_frame_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_valid  (rsp_payload_valid),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_status         (rsp_status),
      .rsp_message_code   (rsp_message_code),
      .rsp_frame_flags    (rsp_frame_flags),
      .rsp_priority_res   (rsp_priority_res),
      .rsp_dest_is_group  (rsp_dest_is_group),
      .rsp_hop_count      (rsp_hop_count),
      .rsp_source_address (rsp_source_address),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_payload_length (rsp_payload_length),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #4 clock = ~clock;

   // Shared run state
   cemi_ldfp_pkg::rsp_item_type predicted_outputs[$];
   logic [7:0]   frame_buf[$];
   int           error_count = 0;
   int           results_checked = 0;
   int           bytes_sent = 0;
   int           frames_sent = 0;
   int           capacity_writes = 0;
   int           status_seen[4] = '{0, 0, 0, 0};
   int           cycle_count = 0;
   int           rsp_hold_cycles = 0;
   bit           no_idle = 1'b0;

   // Parser shadow state
   logic [8:0]  capacity_q;
   logic [9:0]  pos_q;
   logic [7:0]  alen_q;
   logic [7:0]  lbyte_q;
   logic [7:0]  code_q;
   logic [7:0]  ctl1_q;
   logic [7:0]  ctl2_q;
   logic [15:0] src_q;
   logic [15:0] dst_q;

   function automatic void clear_frame_state();
      pos_q   = '0;
      alen_q  = '0;
      lbyte_q = '0;
      code_q  = '0;
      ctl1_q  = '0;
      ctl2_q  = '0;
      src_q   = '0;
      dst_q   = '0;
   endfunction

   // Status of a frame of 'size' bytes; earliest failing check wins
   function automatic logic [1:0] judge_frame(int size);
      int a;
      int lb;
      a  = int'(alen_q);
      lb = int'(lbyte_q);
      if (size < 11) return cemi_ldfp_pkg::STATUS_BAD_SIZE;
      if (code_q != cemi_ldfp_pkg::MC_L_DATA_REQ && code_q != cemi_ldfp_pkg::MC_L_DATA_IND &&
          code_q != cemi_ldfp_pkg::MC_L_DATA_CON)
         return cemi_ldfp_pkg::STATUS_DECODE;
      if (size < 4 + a) return cemi_ldfp_pkg::STATUS_BAD_SIZE;
      if (ctl1_q[7] && ctl2_q[3:0] != 4'd0) return cemi_ldfp_pkg::STATUS_DECODE;
      if (size < 10 + a) return cemi_ldfp_pkg::STATUS_BAD_SIZE;
      if (lb == 0) return cemi_ldfp_pkg::STATUS_DECODE;
      if (size < 10 + a + lb) return cemi_ldfp_pkg::STATUS_BAD_SIZE;
      if (lb + 1 > int'(capacity_q)) return cemi_ldfp_pkg::STATUS_OVER_CAP;
      if (size != 10 + a + lb) return cemi_ldfp_pkg::STATUS_BAD_SIZE;
      return cemi_ldfp_pkg::STATUS_OK;
   endfunction

   // Advance the shadow parser by one byte, queue the output it causes
   function automatic void decode_frame_byte(logic [7:0] b, logic last);
      int                          p;
      int                          a;
      int                          lb;
      bit                          pay;
      cemi_ldfp_pkg::rsp_item_type r;
      p   = int'(pos_q);
      a   = int'(alen_q);
      lb  = int'(lbyte_q);
      pay = 1'b0;
      if (p == 0) code_q = b;
      else if (p == 1) alen_q = b;
      else if (p == 2 + a) ctl1_q = b;
      else if (p == 3 + a) ctl2_q = b;
      else if (p == 4 + a) src_q[15:8] = b;
      else if (p == 5 + a) src_q[7:0] = b;
      else if (p == 6 + a) dst_q[15:8] = b;
      else if (p == 7 + a) dst_q[7:0] = b;
      else if (p == 8 + a) lbyte_q = b;
      else if (p >= 9 + a && p < 10 + a + lb) pay = 1'b1;
      if (pos_q != cemi_ldfp_pkg::POS_MAX) pos_q = pos_q + 10'd1;
      if (!pay && !last) return;
      r = '0;
      if (pay) begin
         r.payload_byte  = b;
         r.payload_valid = 1'b1;
      end
      if (last) begin
         r.frame_done     = 1'b1;
         r.status         = judge_frame(p + 1);
         r.message_code   = code_q;
         r.frame_flags    = {ctl1_q[7], ~ctl1_q[5], ctl1_q[1], ctl1_q[0]};
         r.priority_res   = ctl1_q[3:2];
         r.dest_is_group  = ctl2_q[7];
         r.hop_count      = ctl2_q[6:4];
         r.source_address = src_q;
         r.dest_address   = dst_q;
         r.payload_length = {1'b0, lbyte_q} + 9'd1;
         status_seen[r.status]++;
         clear_frame_state();
      end
      predicted_outputs.push_back(r);
   endfunction

   // Offer one item after a random gap, hold it until taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_frame_byte <= b;
      req_last_byte  <= last;
      do @(posedge clock); while (!req_ready);
      decode_frame_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++)
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
      frames_sent++;
   endtask

   // Assemble a frame: addinfo and payload bytes are random
   function automatic void build_frame(logic [7:0] code, logic [7:0] alen, logic [7:0] c1,
                                       logic [7:0] c2, logic [15:0] src, logic [15:0] dst,
                                       logic [7:0] lbyte);
      frame_buf.delete();
      frame_buf.push_back(code);
      frame_buf.push_back(alen);
      for (int i = 0; i < int'(alen); i++) frame_buf.push_back(8'($urandom));
      frame_buf.push_back(c1);
      frame_buf.push_back(c2);
      frame_buf.push_back(src[15:8]);
      frame_buf.push_back(src[7:0]);
      frame_buf.push_back(dst[15:8]);
      frame_buf.push_back(dst[7:0]);
      frame_buf.push_back(lbyte);
      for (int i = 0; i <= int'(lbyte); i++) frame_buf.push_back(8'($urandom));
   endfunction

   // Stop offering, wait out all results plus the pipeline
   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      while (predicted_outputs.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [8:0] value);
      drain_results(4);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      capacity_q = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      capacity_writes++;
   endtask

   // One random frame: well formed for half of the kinds, the others broken in one chosen way
   task automatic random_frame();
      int          kind;
      int          n;
      int          alen;
      int          lb;
      logic [7:0]  code;
      logic [7:0]  c1;
      logic [7:0]  c2;
      no_idle = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 19);
      case ($urandom_range(0, 2))
         0:       code = cemi_ldfp_pkg::MC_L_DATA_REQ;
         1:       code = cemi_ldfp_pkg::MC_L_DATA_IND;
         default: code = cemi_ldfp_pkg::MC_L_DATA_CON;
      endcase
      alen = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      if ($urandom_range(0, 39) == 0) alen = $urandom_range(7, 40);
      lb = ($urandom_range(0, 24) == 0) ? $urandom_range(16, 255) : $urandom_range(1, 15);
      c1 = 8'($urandom);
      c2 = 8'($urandom);
      if (c1[7]) c2[3:0] = 4'd0;
      n = -1;
      case (kind)
         11: do code = 8'($urandom);
             while (code == cemi_ldfp_pkg::MC_L_DATA_REQ || code == cemi_ldfp_pkg::MC_L_DATA_IND ||
                    code == cemi_ldfp_pkg::MC_L_DATA_CON);
         12: begin
            // cut inside a long addinfo block or right after control field 1
            alen = $urandom_range(8, 20);
            n = $urandom_range(11, 3 + alen);
         end
         13: begin
            c1[7] = 1'b1;
            c2[3:0] = 4'($urandom_range(1, 15));
         end
         14: begin
            // cut between control field 2 and the length byte
            alen = $urandom_range(2, 8);
            n = $urandom_range((4 + alen > 11) ? 4 + alen : 11, 9 + alen);
         end
         15: lb = 0;
         16: begin
            lb = $urandom_range(2, 20);
            n = $urandom_range((10 + alen > 11) ? 10 + alen : 11, 9 + alen + lb);
         end
         17: begin
            // length right at the capacity edge
            lb = int'(capacity_q) - 1 + $urandom_range(0, 2);
            lb = (lb < 1) ? 1 : ((lb > 255) ? 255 : lb);
         end
         10: n = $urandom_range(1, 10);
         default: ;
      endcase
      build_frame(code, 8'(alen), c1, c2, 16'($urandom), 16'($urandom), 8'(lb));
      if (n >= 0)
         while (frame_buf.size() > n) void'(frame_buf.pop_back());
      if (kind == 18)
         repeat ($urandom_range(1, 5)) frame_buf.push_back(8'($urandom));
      if (kind == 19) begin
         // raw noise
         frame_buf.delete();
         repeat ($urandom_range(1, 30)) frame_buf.push_back(8'($urandom));
      end
      send_frame();
   endtask

   // Field extremes, shortest frames, empty TPDU
   task automatic test_edges();
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b1);
      build_frame(cemi_ldfp_pkg::MC_L_DATA_CON, 8'd0, 8'hFF, 8'hF0, 16'hFFFF, 16'hFFFF, 8'd1);
      frame_buf[9]  = 8'hFF;
      frame_buf[10] = 8'h00;
      send_frame();
      build_frame(cemi_ldfp_pkg::MC_L_DATA_IND, 8'd0, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'd0);
      send_frame();
   endtask

   // Largest valid frame: full additional info and the longest TPDU
   task automatic test_longest_frames();
      build_frame(cemi_ldfp_pkg::MC_L_DATA_IND, 8'd255, 8'hB4, 8'hE0, 16'($urandom),
                  16'($urandom), 8'd255);
      send_frame();
   endtask

   // Receiver holds off while bytes stream in back to back
   task automatic test_backpressure();
      rsp_hold_cycles = 150;
      no_idle = 1'b1;
      build_frame(cemi_ldfp_pkg::MC_L_DATA_REQ, 8'd0, 8'hBC, 8'h60, 16'($urandom),
                  16'($urandom), 8'd80);
      send_frame();
      no_idle = 1'b0;
   endtask

   // Random traffic under a sweep of capacity settings
   task automatic test_random_traffic();
      int          start;
      logic [8:0]  caps[7];
      caps = '{9'd256, 9'd2, 9'd255, 9'($urandom_range(3, 254)), 9'd0, 9'd511, 9'd256};
      foreach (caps[k]) begin
         if (k > 0) set_capacity(caps[k]);
         start = bytes_sent;
         while (bytes_sent - start < 80) random_frame();
      end
   endtask

   // Result side: random stall per item, plus a requested long hold
   initial begin : rsp_ready_driver
      int stall;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = no_idle ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic check_field(input string label, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         error_count++;
      end
   endtask

   // Compare every accepted output against the oldest prediction
   always @(posedge clock) begin : check_outputs
      cemi_ldfp_pkg::rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_outputs.size() == 0) begin
            $display("%0t: unexpected output, expected none, actual payload %0h done %0b",
                     $time, rsp_payload_byte, rsp_frame_done);
            error_count++;
         end else begin
            want = predicted_outputs.pop_front();
            check_field("payload_byte", int'(want.payload_byte), int'(rsp_payload_byte));
            check_field("payload_valid", int'(want.payload_valid), int'(rsp_payload_valid));
            check_field("frame_done", int'(want.frame_done), int'(rsp_frame_done));
            check_field("status", int'(want.status), int'(rsp_status));
            check_field("message_code", int'(want.message_code), int'(rsp_message_code));
            check_field("frame_flags", int'(want.frame_flags), int'(rsp_frame_flags));
            check_field("priority_res", int'(want.priority_res), int'(rsp_priority_res));
            check_field("dest_is_group", int'(want.dest_is_group), int'(rsp_dest_is_group));
            check_field("hop_count", int'(want.hop_count), int'(rsp_hop_count));
            check_field("source_address", int'(want.source_address),
                        int'(rsp_source_address));
            check_field("dest_address", int'(want.dest_address), int'(rsp_dest_address));
            check_field("payload_length", int'(want.payload_length),
                        int'(rsp_payload_length));
            results_checked++;
         end
      end
   end

   // Hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d outputs outstanding", $time, predicted_outputs.size());
         $display("cemi_ldata_frame_parser_unit test failed");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_frame_byte   = 8'h00;
      req_last_byte    = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = 9'd0;
      capacity_q       = cemi_ldfp_pkg::CAPACITY_RESET;
      clear_frame_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_edges();
      test_longest_frames();
      test_backpressure();
      test_random_traffic();
      drain_results(8);

      $display("Run: %0d bytes in %0d frames, %0d outputs checked, %0d capacity writes",
               bytes_sent, frames_sent, results_checked, capacity_writes);
      $display("Frame endings: %0d ok, %0d bad size, %0d decode failure, %0d over capacity",
               status_seen[cemi_ldfp_pkg::STATUS_OK], status_seen[cemi_ldfp_pkg::STATUS_BAD_SIZE],
               status_seen[cemi_ldfp_pkg::STATUS_DECODE],
               status_seen[cemi_ldfp_pkg::STATUS_OVER_CAP]);
      if (error_count == 0) begin
         $display("cemi_ldata_frame_parser_unit test passed");
      end else begin
         $display("cemi_ldata_frame_parser_unit test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
